// ===== rtl/core/mws_pkg.sv =====
`default_nettype none
package mws_pkg;

    localparam int NUM_BINS    = 2048;
    localparam int NUM_SOURCES = 4;
    localparam int FRAC_BITS   = 16;
    localparam int SLOTS       = 4;
    localparam int SRC_USED    = (NUM_SOURCES < SLOTS) ? NUM_SOURCES : SLOTS;
    localparam int BIN_W       = 11;
    localparam int ADDR_W      = BIN_W + 4;
    localparam int DEPTH       = SLOTS * 4 * (1 << BIN_W);
    localparam int ACC_W       = 66;
    localparam int DIV_W       = 32 + 2 * FRAC_BITS;
    localparam int DCNT_W      = $clog2(DIV_W);

    localparam logic [1:0] CMD_LOAD_COV = 2'd0;
    localparam logic [1:0] CMD_LOAD_PSD = 2'd1;
    localparam logic [1:0] CMD_SEPARATE = 2'd2;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_cplx;

    typedef struct packed {
        logic                    issue;
        logic                    raw;
        logic                    neg;
        logic                    dst_im;
        logic                    clr;
        logic signed [ACC_W-1:0] init;
    } t_mac_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(ACC_W-32){1'b0}}, 32'h7FFFFFFF})) begin
            r = 32'sh7FFFFFFF;
        end else if (x < $signed({{(ACC_W-32){1'b1}}, 32'h80000000})) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/multichannel_wiener_separation.sv =====
`default_nettype none
// Load commands (covariance element, PSD) complete in the accept cycle: one transaction/cycle while idle.
// A separate command fetches the bin's 16 covariances, then runs its products through one shared
// 32x32 multiply-accumulate (one product per cycle within a group) plus a bit-serial divider run twice.
// Four results follow, one per source; unless singular, each source recomputes its gain and output groups.
// The input is stalled for the whole separate run; results wait in an output register.
// Reset (i_rst_n low, synchronous) clears control, PSD registers, regularization to 1.
module multichannel_wiener_separation
    import mws_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic [BIN_W-1:0]   i_bin,
    input  wire logic [1:0]         i_source,
    input  wire logic [1:0]         i_element,
    input  wire logic signed [31:0] i_value_re,
    input  wire logic signed [31:0] i_value_im,
    input  wire logic signed [31:0] i_mix_left_re,
    input  wire logic signed [31:0] i_mix_left_im,
    input  wire logic signed [31:0] i_mix_right_re,
    input  wire logic signed [31:0] i_mix_right_im,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_source_id,
    output logic signed [31:0]      o_est_left_re,
    output logic signed [31:0]      o_est_left_im,
    output logic signed [31:0]      o_est_right_re,
    output logic signed [31:0]      o_est_right_im,
    output logic                    o_singular,
    output logic                    o_last
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_GRP, S_DIV, S_OUT} t_state;

    // one group = a few complex products summed, then saturated into a register (GK_NORM keeps the raw sum)
    typedef enum logic [2:0] {
        GK_C, GK_DET, GK_NORM, GK_INV, GK_GAIN, GK_SCALE, GK_Y
    } t_grp;

    t_state             r_state;
    t_grp               r_grp;
    logic [1:0]         r_gi;
    logic [1:0]         r_src;
    logic [4:0]         r_k;
    logic               r_dpart;
    logic               r_dgo;
    logic               r_sing;
    logic [15:0]        r_reg;
    logic signed [31:0] r_psd [SLOTS];
    logic [BIN_W-1:0]   r_bin;
    t_cplx              r_x0, r_x1;
    t_cplx              r_r [16];
    t_cplx              r_c [4];
    t_cplx              r_det, r_iv, r_gt;
    t_cplx              r_inv [4];
    t_cplx              r_gain [4];
    t_cplx              r_y [2];
    logic [63:0]        r_n;

    logic                    w_accept;
    logic                    w_bin_ok;
    logic [63:0]             w_rdata;
    logic [ADDR_W-1:0]       w_raddr;
    t_mac_ctl                w_ctl;
    logic signed [31:0]      w_a, w_b;
    logic signed [ACC_W-1:0] w_acc_re, w_acc_im;
    logic signed [31:0]      w_sre, w_sim;
    t_cplx                   w_ca, w_cb;
    logic                    w_sg, w_conj, w_raw;
    logic [2:0]              w_np;
    logic [4:0]              w_last_k;
    logic                    w_div_busy, w_div_done;
    logic [DIV_W-1:0]        w_quot;
    logic [31:0]             w_num;
    logic [32:0]             w_qc;
    logic signed [33:0]      w_qs;
    logic                    w_qneg;
    logic signed [31:0]      w_ivp;
    logic                    w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_bin_ok   = ({2'b0, r_bin} < 13'(NUM_BINS));
    assign w_raddr    = {r_bin, r_k[3:0]};
    assign w_out_free = !o_out_valid || !i_out_stall;

    mws_cov_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_command == CMD_LOAD_COV)
                  && ({2'b0, i_bin} < 13'(NUM_BINS)) && ({1'b0, i_source} < 3'(SRC_USED))),
        .i_waddr ({i_bin, i_source, i_element}),
        .i_wdata ({i_value_re, i_value_im}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // operand selection for the shared multiplier
    always_comb begin
        w_ca   = '0;
        w_cb   = '0;
        w_sg   = 1'b0;
        w_conj = 1'b0;
        w_raw  = 1'b0;
        w_np   = 3'd1;
        unique case (r_grp)
            GK_C: begin
                w_ca = '{re: r_psd[r_k[3:2]], im: 32'sd0};
                w_cb = r_r[{r_k[3:2], r_gi}];
                w_np = 3'(SRC_USED);
            end
            GK_DET: begin
                w_np = 3'd2;
                if (!r_k[2]) begin
                    w_ca = r_c[0];
                    w_cb = r_c[3];
                end else begin
                    w_ca = r_c[1];
                    w_cb = r_c[2];
                    w_sg = 1'b1;
                end
            end
            GK_NORM: begin
                // det * conj(det), unscaled: re part is the squared magnitude
                w_ca   = r_det;
                w_cb   = r_det;
                w_conj = 1'b1;
                w_raw  = 1'b1;
            end
            GK_INV: begin
                w_ca = r_iv;
                unique case (r_gi)
                    2'd0: w_cb = r_c[3];
                    2'd1: begin
                        w_cb = r_c[1];
                        w_sg = 1'b1;
                    end
                    2'd2: begin
                        w_cb = r_c[2];
                        w_sg = 1'b1;
                    end
                    default: w_cb = r_c[0];
                endcase
            end
            GK_GAIN: begin
                w_np = 3'd2;
                w_ca = r_r[{r_src, r_gi[1], r_k[2]}];
                w_cb = r_inv[{r_k[2], r_gi[0]}];
            end
            GK_SCALE: begin
                w_ca = '{re: r_psd[r_src], im: 32'sd0};
                w_cb = r_gt;
            end
            default: begin
                w_np = 3'd2;
                w_ca = r_gain[{r_gi[0], r_k[2]}];
                w_cb = r_k[2] ? r_x1 : r_x0;
            end
        endcase
    end

    assign w_last_k = {w_np, 2'b01};

    always_comb begin
        w_ctl.issue  = (r_state == S_GRP) && (r_k < {w_np, 2'b00});
        w_ctl.raw    = w_raw;
        w_ctl.clr    = (r_state == S_GRP) && (r_k == '0);
        w_ctl.init   = '0;
        if (r_grp == GK_C && (r_gi == 2'd0 || r_gi == 2'd3)) begin
            w_ctl.init = ACC_W'(r_reg) * ACC_W'(SRC_USED);
        end
        unique case (r_k[1:0])
            2'd0: begin
                w_a = w_ca.re;
                w_b = w_cb.re;
                w_ctl.dst_im = 1'b0;
                w_ctl.neg    = w_sg;
            end
            2'd1: begin
                w_a = w_ca.im;
                w_b = w_cb.im;
                w_ctl.dst_im = 1'b0;
                w_ctl.neg    = w_sg ^ ~w_conj;
            end
            2'd2: begin
                w_a = w_ca.re;
                w_b = w_cb.im;
                w_ctl.dst_im = 1'b1;
                w_ctl.neg    = w_sg ^ w_conj;
            end
            default: begin
                w_a = w_ca.im;
                w_b = w_cb.re;
                w_ctl.dst_im = 1'b1;
                w_ctl.neg    = w_sg;
            end
        endcase
    end

    mws_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_acc_re (w_acc_re),
        .o_acc_im (w_acc_im)
    );

    assign w_sre = sat32(w_acc_re);
    assign w_sim = sat32(w_acc_im);

    // inverse determinant part: |det part| * 2^(2F) / |det|^2
    assign w_num = r_dpart ? (r_det.im[31] ? 32'(-r_det.im) : r_det.im)
                           : (r_det.re[31] ? 32'(-r_det.re) : r_det.re);

    mws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dgo),
        .i_num   (w_num),
        .i_den   (r_n),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_qc   = (w_quot > DIV_W'(64'h1_0000_0000)) ? 33'h1_0000_0000 : w_quot[32:0];
    assign w_qneg = r_dpart ? !r_det.im[31] : r_det.re[31];
    assign w_qs   = w_qneg ? -$signed({1'b0, w_qc}) : $signed({1'b0, w_qc});
    assign w_ivp  = sat32(ACC_W'(w_qs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grp       <= GK_C;
            r_gi        <= '0;
            r_src       <= '0;
            r_k         <= '0;
            r_dpart     <= 1'b0;
            r_dgo       <= 1'b0;
            r_sing      <= 1'b0;
            r_reg       <= 16'd1;
            o_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_psd[i] <= '0;
            end
        end else begin
            r_dgo <= 1'b0;
            if (i_cfg_we) begin
                r_reg <= i_cfg_wdata;
            end
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_command == CMD_LOAD_PSD && {1'b0, i_source} < 3'(SRC_USED)) begin
                            r_psd[i_source] <= i_value_re;
                        end
                        if (i_command == CMD_SEPARATE) begin
                            r_bin   <= i_bin;
                            r_x0    <= '{re: i_mix_left_re, im: i_mix_left_im};
                            r_x1    <= '{re: i_mix_right_re, im: i_mix_right_im};
                            r_sing  <= 1'b0;
                            r_k     <= '0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // read data is registered, so it arrives the cycle after its address
                    if (r_k != '0) begin
                        r_r[4'(r_k - 1'b1)] <= w_bin_ok ? t_cplx'(w_rdata) : '0;
                    end
                    if (r_k == 5'd16) begin
                        r_k     <= '0;
                        r_grp   <= GK_C;
                        r_gi    <= '0;
                        r_state <= S_GRP;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_GRP: begin
                    if (r_k != w_last_k) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_k <= '0;
                        unique case (r_grp)
                            GK_C: begin
                                r_c[r_gi] <= '{re: w_sre, im: w_sim};
                                if (r_gi == 2'd3) begin
                                    r_grp <= GK_DET;
                                end
                                r_gi <= r_gi + 1'b1;
                            end
                            GK_DET: begin
                                r_det <= '{re: w_sre, im: w_sim};
                                if (w_sre == '0 && w_sim == '0) begin
                                    r_sing  <= 1'b1;
                                    r_src   <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_grp <= GK_NORM;
                                end
                            end
                            GK_NORM: begin
                                r_n     <= w_acc_re[63:0];
                                r_dpart <= 1'b0;
                                r_dgo   <= 1'b1;
                                r_state <= S_DIV;
                            end
                            GK_INV: begin
                                r_inv[r_gi] <= '{re: w_sre, im: w_sim};
                                if (r_gi == 2'd3) begin
                                    r_grp <= GK_GAIN;
                                    r_src <= '0;
                                end
                                r_gi <= r_gi + 1'b1;
                            end
                            GK_GAIN: begin
                                r_gt  <= '{re: w_sre, im: w_sim};
                                r_grp <= GK_SCALE;
                            end
                            GK_SCALE: begin
                                r_gain[r_gi] <= '{re: w_sre, im: w_sim};
                                r_grp        <= (r_gi == 2'd3) ? GK_Y : GK_GAIN;
                                r_gi         <= r_gi + 1'b1;
                            end
                            default: begin
                                r_y[r_gi[0]] <= '{re: w_sre, im: w_sim};
                                if (r_gi[0]) begin
                                    r_state <= S_OUT;
                                end
                                r_gi <= {1'b0, ~r_gi[0]};
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (!r_dpart) begin
                            r_iv.re <= w_ivp;
                            r_dpart <= 1'b1;
                            r_dgo   <= 1'b1;
                        end else begin
                            r_iv.im <= w_ivp;
                            r_grp   <= GK_INV;
                            r_gi    <= '0;
                            r_k     <= '0;
                            r_state <= S_GRP;
                        end
                    end
                end
                default: begin
                    if (w_out_free) begin
                        o_out_valid    <= 1'b1;
                        o_source_id    <= r_src;
                        o_singular     <= r_sing;
                        o_last         <= (r_src == 2'(SRC_USED - 1));
                        o_est_left_re  <= r_sing ? 32'sh7FFFFFFF : r_y[0].re;
                        o_est_left_im  <= r_sing ? 32'sh7FFFFFFF : r_y[0].im;
                        o_est_right_re <= r_sing ? 32'sh7FFFFFFF : r_y[1].re;
                        o_est_right_im <= r_sing ? 32'sh7FFFFFFF : r_y[1].im;
                        if (r_src == 2'(SRC_USED - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_src <= r_src + 1'b1;
                            if (!r_sing) begin
                                r_grp   <= GK_GAIN;
                                r_gi    <= '0;
                                r_k     <= '0;
                                r_state <= S_GRP;
                            end
                        end
                    end
                end
            endcase
        end
    end

`ifndef SYNTH
    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> r_state == S_DIV)
        else $error("divider running outside divide phase");
    a_sing_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> o_est_left_re == 32'sh7FFFFFFF
                                      && o_est_right_im == 32'sh7FFFFFFF)
        else $error("singular result not saturated");
    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_source_id == 2'(SRC_USED - 1))
        else $error("last flag on wrong source");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GRP |-> r_k <= w_last_k)
        else $error("group step counter overran");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mws_cov_mem.sv =====
`default_nettype none
module mws_cov_mem
    import mws_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [63:0]       i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [63:0]       o_rdata
);

    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/mws_mac.sv =====
`default_nettype none
module mws_mac
    import mws_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_mac_ctl           i_ctl,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [ACC_W-1:0] o_acc_re,
    output logic signed [ACC_W-1:0] o_acc_im
);

    logic signed [63:0]      r_p;
    logic                    r_pv;
    logic                    r_pneg;
    logic                    r_pim;
    logic                    r_praw;
    logic signed [ACC_W-1:0] w_term;
    logic signed [63:0]      w_sh;

    // shift right is floor rounding of the product
    assign w_sh   = r_praw ? r_p : (r_p >>> FRAC_BITS);
    assign w_term = r_pneg ? -{{(ACC_W-64){w_sh[63]}}, w_sh}
                           : {{(ACC_W-64){w_sh[63]}}, w_sh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
        r_p    <= i_a * i_b;
        r_pneg <= i_ctl.neg;
        r_pim  <= i_ctl.dst_im;
        r_praw <= i_ctl.raw;
        if (i_ctl.clr) begin
            o_acc_re <= i_ctl.init;
            o_acc_im <= '0;
        end else if (r_pv) begin
            if (r_pim) begin
                o_acc_im <= o_acc_im + w_term;
            end else begin
                o_acc_re <= o_acc_re + w_term;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mws_div.sv =====
`default_nettype none
module mws_div
    import mws_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_num,
    input  wire logic [63:0]      i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quot
);

    logic [DIV_W-1:0]  r_dvd;
    logic [64:0]       r_rem;
    logic [63:0]       r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic [64:0]       w_t;
    logic              w_ge;

    assign w_t  = {r_rem[63:0], r_dvd[DIV_W-1]};
    assign w_ge = (w_t >= {1'b0, r_den});

    // restoring long division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                o_busy <= 1'b1;
                r_rem  <= '0;
                r_dvd  <= {i_num, {(2 * FRAC_BITS){1'b0}}};
                r_den  <= i_den;
                o_quot <= '0;
                r_cnt  <= DCNT_W'(DIV_W - 1);
            end else if (o_busy) begin
                r_rem  <= w_ge ? (w_t - {1'b0, r_den}) : w_t;
                o_quot <= {o_quot[DIV_W-2:0], w_ge};
                r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    o_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire
